>>> src/assert_macros.svh
// Assertion macros shared by the RTL of the sphere overlap block.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> src/sosc_pkg.sv
// Shared types and constants of the sphere overlap exclusion check.
// No dependencies; used by the channel interfaces and the top level.
package sosc_pkg;

  localparam int RAD_W      = 16;
  localparam int FRAC_W     = 20;
  localparam int SIZE_W     = 11;
  localparam int OP_W       = 2;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 36;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Divider operand widths
  localparam int NUM_W = 78;
  localparam int DEN_W = 65;
  localparam int DV_W  = DEN_W + 19;

  typedef logic [FRAC_W-1:0] frac_t;
  typedef logic [RAD_W-1:0]  rad_t;
  typedef logic [OP_W-1:0]   op_t;
  typedef logic [SIZE_W-1:0] size_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_QUERY  = 2'd1;
  localparam op_t OP_CLEAR  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_WRAP   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_X = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_Y = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_Z = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT  = 3'd4;

  localparam frac_t FRAC_MAX  = 20'hFFFFF;
  localparam logic  WRAP_RST  = 1'b1;
  localparam size_t SIZE_RST  = 11'd256;
  localparam frac_t LIMIT_RST = 20'd0;

endpackage

>>> src/sosc_ifs.sv
// Valid/ready channel interfaces for items and results.
// Depends on sosc_pkg for field types.
interface sosc_in_if #(parameter int COORD_BITS = 10) ();
  logic                   valid;
  logic                   ready;
  sosc_pkg::op_t          opcode;
  logic [COORD_BITS-1:0]  pos_x;
  logic [COORD_BITS-1:0]  pos_y;
  logic [COORD_BITS-1:0]  pos_z;
  sosc_pkg::rad_t         radius;

  modport source (output valid, opcode, pos_x, pos_y, pos_z, radius, input ready);
  modport sink   (input valid, opcode, pos_x, pos_y, pos_z, radius, output ready);
endinterface

interface sosc_out_if ();
  logic            valid;
  logic            ready;
  logic            status;
  logic            overlap_exceeded;
  sosc_pkg::frac_t total_overlap;

  modport source (output valid, status, overlap_exceeded, total_overlap, input ready);
  modport sink   (input valid, status, overlap_exceeded, total_overlap, output ready);
endinterface

>>> src/sosc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sosc_ram #(
  parameter int WIDTH = 46,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/sphere_overlap_exclusion_check_top.sv
// Sphere overlap exclusion check: sphere table, query sequencer and shared arithmetic.
// Depends on sosc_pkg, sosc_ifs (channels), sosc_ram and assert_macros.svh.
//
// Usage: items arrive on in_ch (valid/ready); each yields exactly one result on out_ch.
// Opcode insert appends a sphere to the table held in a RAM, clear empties the table,
// query walks the stored spheres in order and sums the lens volume shared with the
// candidate as a Q8.12 fraction of the candidate volume (saturating), reporting the
// total and whether it exceeds overlap_limit. Registers are written over the APB port.
// Insert, clear and unused opcodes go straight to the done state, which loads the
// result register once it is free. A query forms the candidate cube on the shared
// 17x36 multiplier, then sorts each visited entry as apart, contained (one holds the
// other) or lens; the last two end in a 20-step divider, skipped if the fraction
// saturates, a lens after a 17-step square root. The walk stops early once the total
// exceeds the limit. One item is in work at a time; the next item is taken as soon
// as the result has moved to the output register, even if out_ch stalls.
// A stalled receiver holds the result; the finished item then waits to hand over.
// Reset empties the table (count to zero), restores the register defaults and drops
// any pending result. The table RAM needs no clearing pass.
`include "assert_macros.svh"

module sphere_overlap_exclusion_check_top #(
  parameter int MAX_SPHERES = 1024,
  parameter int COORD_BITS  = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  sosc_in_if.sink                           in_ch,
  sosc_out_if.source                        out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sosc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int CNT_W  = $clog2(MAX_SPHERES + 1);
  localparam int ADDR_W = $clog2(MAX_SPHERES);
  localparam int ENT_W  = 3 * COORD_BITS + sosc_pkg::RAD_W;
  localparam int AXW    = ((COORD_BITS > sosc_pkg::SIZE_W) ? COORD_BITS
                                                           : sosc_pkg::SIZE_W) + 1;
  localparam int DW     = AXW + 1;
  localparam int SQ_W   = 2 * AXW;
  localparam int D2_W   = SQ_W + 2;
  localparam int DS_W   = D2_W + 16;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_QC2  = 5'd1;
  localparam logic [4:0] S_QC3  = 5'd2;
  localparam logic [4:0] S_RD   = 5'd3;
  localparam logic [4:0] S_LD   = 5'd4;
  localparam logic [4:0] S_AB   = 5'd5;
  localparam logic [4:0] S_MX   = 5'd6;
  localparam logic [4:0] S_MY   = 5'd7;
  localparam logic [4:0] S_MZ   = 5'd8;
  localparam logic [4:0] S_SS   = 5'd9;
  localparam logic [4:0] S_DD   = 5'd10;
  localparam logic [4:0] S_CL   = 5'd11;
  localparam logic [4:0] S_MN2  = 5'd12;
  localparam logic [4:0] S_MN3  = 5'd13;
  localparam logic [4:0] S_SQ   = 5'd14;
  localparam logic [4:0] S_L1   = 5'd15;
  localparam logic [4:0] S_L2   = 5'd16;
  localparam logic [4:0] S_L3   = 5'd17;
  localparam logic [4:0] S_L4   = 5'd18;
  localparam logic [4:0] S_L5   = 5'd19;
  localparam logic [4:0] S_L6   = 5'd20;
  localparam logic [4:0] S_L7   = 5'd21;
  localparam logic [4:0] S_L8   = 5'd22;
  localparam logic [4:0] S_DV0  = 5'd23;
  localparam logic [4:0] S_DV   = 5'd24;
  localparam logic [4:0] S_ACC  = 5'd25;
  localparam logic [4:0] S_DONE = 5'd26;

  // Control state
  logic [4:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  idx_r;
  logic [4:0]        cnt_r;

  // Configuration registers
  logic                  wrap_r;
  sosc_pkg::size_t       size_r [3];
  sosc_pkg::frac_t       limit_r;

  // Candidate and entry operands
  logic [COORD_BITS-1:0] cpos_r [3];
  sosc_pkg::rad_t        crad_r;
  sosc_pkg::rad_t        erad_r;
  logic signed [DW-1:0]  dw_r [3];
  logic [AXW-1:0]        adiff_r [3];
  logic [16:0]           s_r;
  logic [15:0]           dif_r;
  logic [15:0]           mn_r;

  // Products and intermediate values
  logic [31:0]           ccsq_r;
  logic [47:0]           ccube_r;
  logic [SQ_W-1:0]       sq_r [3];
  logic [D2_W-1:0]       d2_r;
  logic [33:0]           ssq_r;
  logic [31:0]           dsq_r;
  logic [31:0]           msq_r;
  logic [33:0]           sx_r;
  logic [18:0]           srem_r;
  logic [16:0]           root_r;
  logic [33:0]           dd_r;
  logic [16:0]           e_r;
  logic [33:0]           dsr_r;
  logic [33:0]           esq_r;
  logic [35:0]           b_r;
  logic [sosc_pkg::MUL_P_W-1:0] plo_r;
  logic [sosc_pkg::MUL_P_W-1:0] phi_r;
  logic [40:0]           dlo_r;
  logic [40:0]           dhi_r;
  logic [sosc_pkg::NUM_W-1:0] num_r;
  logic [sosc_pkg::DEN_W-1:0] den_r;
  logic [sosc_pkg::DV_W-1:0]  dv_r;
  logic [19:0]           q_r;
  sosc_pkg::frac_t       frac_r;
  sosc_pkg::frac_t       total_r;
  logic                  status_r;

  // Output register
  logic                  out_valid_r;
  logic                  out_status_r;
  logic                  out_exc_r;
  sosc_pkg::frac_t       out_total_r;

  // Combinational signals
  logic                  in_fire;
  logic                  out_free;
  logic                  tab_full;
  logic                  walk_stop;
  logic                  ram_we;
  logic                  ram_re;
  logic [ENT_W-1:0]      ram_wdata;
  logic [ENT_W-1:0]      ram_rdata;
  logic [sosc_pkg::MUL_A_W-1:0] mul_a;
  logic [sosc_pkg::MUL_B_W-1:0] mul_b;
  logic [sosc_pkg::MUL_P_W-1:0] mul_p;
  logic [DS_W-1:0]       ds;
  logic                  is_apart;
  logic                  is_cont;
  logic [20:0]           srem_w;
  logic [20:0]           strial;
  logic                  sge;
  logic [20:0]           srem_sub;
  logic                  dv_le;
  logic [sosc_pkg::DV_W-1:0] dsub;
  logic                  div_sat;
  logic [20:0]           acc_sum;
  logic signed [DW-1:0]  d1 [3];
  logic signed [DW-1:0]  d2x [3];
  logic [AXW-1:0]        adiff_w [3];
  logic                  cfg_wr;
  logic [sosc_pkg::REG_IDX_W-1:0] cfg_idx;

  // Handshakes
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign tab_full    = (count_r >= CNT_W'(MAX_SPHERES));
  assign walk_stop   = (idx_r >= count_r) || (total_r > limit_r);

  // Table RAM: append on insert, read one entry per visit
  assign ram_we    = in_fire && (in_ch.opcode == sosc_pkg::OP_INSERT) && !tab_full;
  assign ram_wdata = {in_ch.pos_z, in_ch.pos_y, in_ch.pos_x, in_ch.radius};
  assign ram_re    = (state_r == S_RD) && !walk_stop;

  sosc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_SPHERES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Minimum-image differences: first correction from RAM data, second and abs later
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [DW-1:0] d0;
      logic signed [DW-1:0] hv;
      logic signed [DW-1:0] sz;
      hv = $signed(DW'(size_r[a] >> 1));
      sz = $signed(DW'(size_r[a]));
      d0 = $signed(DW'(cpos_r[a]))
         - $signed(DW'(ram_rdata[sosc_pkg::RAD_W + a*COORD_BITS +: COORD_BITS]));
      d1[a]  = (wrap_r && (d0 > hv)) ? d0 - sz : d0;
      d2x[a] = (wrap_r && (dw_r[a] < -hv)) ? dw_r[a] + sz : dw_r[a];
      adiff_w[a] = (d2x[a] < 0) ? AXW'(-d2x[a]) : AXW'(d2x[a]);
    end
  end

  // Select operands of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_QC2: begin mul_a = 17'(crad_r);        mul_b = 36'(crad_r);         end
      S_QC3: begin mul_a = 17'(crad_r);        mul_b = 36'(ccsq_r);         end
      S_MX:  begin mul_a = 17'(adiff_r[0]);    mul_b = 36'(adiff_r[0]);     end
      S_MY:  begin mul_a = 17'(adiff_r[1]);    mul_b = 36'(adiff_r[1]);     end
      S_MZ:  begin mul_a = 17'(adiff_r[2]);    mul_b = 36'(adiff_r[2]);     end
      S_SS:  begin mul_a = s_r;                mul_b = 36'(s_r);            end
      S_DD:  begin mul_a = 17'(dif_r);         mul_b = 36'(dif_r);          end
      S_MN2: begin mul_a = 17'(mn_r);          mul_b = 36'(mn_r);           end
      S_MN3: begin mul_a = 17'(mn_r);          mul_b = 36'(msq_r);          end
      S_L1:  begin mul_a = root_r;             mul_b = 36'(root_r);         end
      S_L2:  begin mul_a = root_r;             mul_b = 36'(s_r);            end
      S_L3:  begin mul_a = e_r;                mul_b = 36'(e_r);            end
      S_L4:  begin mul_a = esq_r[16:0];        mul_b = b_r;                 end
      S_L5:  begin mul_a = esq_r[33:17];       mul_b = b_r;                 end
      S_L6:  begin mul_a = root_r;             mul_b = 36'(ccube_r[23:0]);  end
      S_L7:  begin mul_a = root_r;             mul_b = 36'(ccube_r[47:24]); end
      default: begin mul_a = '0;               mul_b = '0;                  end
    endcase
  end

  assign mul_p = sosc_pkg::MUL_P_W'(mul_a) * sosc_pkg::MUL_P_W'(mul_b);

  // Classify the pair: apart, contained or lens
  assign ds       = {d2_r, 16'b0};
  assign is_apart = (crad_r == '0) || (ds >= DS_W'(ssq_r));
  assign is_cont  = (ds <= DS_W'(dsq_r));

  // Square root step: two bits of radicand per cycle
  assign srem_w   = {srem_r, sx_r[33:32]};
  assign strial   = {2'b00, root_r, 2'b01};
  assign sge      = (srem_w >= strial);
  assign srem_sub = srem_w - strial;

  // Restoring divider step and saturation check
  assign dv_le   = (dv_r <= sosc_pkg::DV_W'(num_r));
  assign dsub    = sosc_pkg::DV_W'(num_r) - dv_r;
  assign div_sat = ({den_r, 20'b0} <= (sosc_pkg::DEN_W + 20)'(num_r));
  assign acc_sum = {1'b0, total_r} + {1'b0, frac_r};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) begin
        state_nxt = (in_ch.opcode == sosc_pkg::OP_QUERY) ? S_QC2 : S_DONE;
      end
      S_QC2:  state_nxt = S_QC3;
      S_QC3:  state_nxt = S_RD;
      S_RD:   state_nxt = walk_stop ? S_DONE : S_LD;
      S_LD:   state_nxt = S_AB;
      S_AB:   state_nxt = S_MX;
      S_MX:   state_nxt = S_MY;
      S_MY:   state_nxt = S_MZ;
      S_MZ:   state_nxt = S_SS;
      S_SS:   state_nxt = S_DD;
      S_DD:   state_nxt = S_CL;
      S_CL: begin
        if (is_apart) begin
          state_nxt = S_ACC;
        end else if (is_cont) begin
          state_nxt = S_MN2;
        end else begin
          state_nxt = S_SQ;
        end
      end
      S_MN2:  state_nxt = S_MN3;
      S_MN3:  state_nxt = S_DV0;
      S_SQ:   state_nxt = (cnt_r == '0) ? S_L1 : S_SQ;
      S_L1:   state_nxt = S_L2;
      S_L2:   state_nxt = S_L3;
      S_L3:   state_nxt = S_L4;
      S_L4:   state_nxt = S_L5;
      S_L5:   state_nxt = S_L6;
      S_L6:   state_nxt = S_L7;
      S_L7:   state_nxt = S_L8;
      S_L8:   state_nxt = S_DV0;
      S_DV0:  state_nxt = div_sat ? S_ACC : S_DV;
      S_DV:   state_nxt = (cnt_r == '0) ? S_ACC : S_DV;
      S_ACC:  state_nxt = S_RD;
      S_DONE: state_nxt = out_free ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      idx_r    <= '0;
      total_r  <= '0;
      status_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        total_r  <= '0;
        idx_r    <= '0;
        status_r <= (in_ch.opcode == sosc_pkg::OP_INSERT) && tab_full;
        if (ram_we) begin
          count_r <= count_r + 1'b1;
        end else if (in_ch.opcode == sosc_pkg::OP_CLEAR) begin
          count_r <= '0;
        end
      end
      // Add the entry's fraction with saturation, advance to the next entry
      if (state_r == S_ACC) begin
        total_r <= acc_sum[20] ? sosc_pkg::FRAC_MAX : acc_sum[19:0];
        idx_r   <= idx_r + 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cpos_r[0] <= in_ch.pos_x;
      cpos_r[1] <= in_ch.pos_y;
      cpos_r[2] <= in_ch.pos_z;
      crad_r    <= in_ch.radius;
    end
    case (state_r)
      S_QC2: ccsq_r  <= mul_p[31:0];
      S_QC3: ccube_r <= mul_p[47:0];
      S_LD: begin
        erad_r <= ram_rdata[sosc_pkg::RAD_W-1:0];
        for (int a = 0; a < 3; a++) begin
          dw_r[a] <= d1[a];
        end
      end
      S_AB: begin
        for (int a = 0; a < 3; a++) begin
          adiff_r[a] <= adiff_w[a];
        end
        s_r   <= 17'(erad_r) + 17'(crad_r);
        dif_r <= (erad_r > crad_r) ? erad_r - crad_r : crad_r - erad_r;
        mn_r  <= (erad_r < crad_r) ? erad_r : crad_r;
      end
      S_MX: sq_r[0] <= mul_p[SQ_W-1:0];
      S_MY: sq_r[1] <= mul_p[SQ_W-1:0];
      S_MZ: sq_r[2] <= mul_p[SQ_W-1:0];
      S_SS: begin
        ssq_r <= mul_p[33:0];
        d2_r  <= D2_W'(sq_r[0]) + D2_W'(sq_r[1]) + D2_W'(sq_r[2]);
      end
      S_DD: dsq_r <= mul_p[31:0];
      S_CL: begin
        frac_r <= '0;
        sx_r   <= ds[33:0];
        srem_r <= '0;
        root_r <= '0;
        cnt_r  <= 5'd16;
      end
      S_MN2: msq_r <= mul_p[31:0];
      S_MN3: begin
        num_r <= sosc_pkg::NUM_W'({mul_p[47:0], 12'b0});
        den_r <= sosc_pkg::DEN_W'(ccube_r);
      end
      // Iterate the square root, shift in two radicand bits per step
      S_SQ: begin
        srem_r <= sge ? srem_sub[18:0] : srem_w[18:0];
        root_r <= {root_r[15:0], sge};
        sx_r   <= {sx_r[31:0], 2'b00};
        cnt_r  <= cnt_r - 1'b1;
      end
      S_L1: begin
        dd_r <= mul_p[33:0];
        e_r  <= s_r - root_r;
      end
      S_L2: dsr_r <= mul_p[33:0];
      S_L3: begin
        esq_r <= mul_p[33:0];
        b_r   <= 36'(dd_r) + 36'({dsr_r, 1'b0}) - 36'(dsq_r) - 36'({dsq_r, 1'b0});
      end
      S_L4: plo_r <= mul_p;
      S_L5: phi_r <= mul_p;
      S_L6: dlo_r <= mul_p[40:0];
      S_L7: dhi_r <= mul_p[40:0];
      S_L8: begin
        num_r <= {70'({phi_r, 17'b0}) + 70'(plo_r), 8'b0};
        den_r <= sosc_pkg::DEN_W'({dhi_r, 24'b0}) + sosc_pkg::DEN_W'(dlo_r);
      end
      S_DV0: begin
        frac_r <= sosc_pkg::FRAC_MAX;
        dv_r   <= {den_r, 19'b0};
        q_r    <= '0;
        cnt_r  <= 5'd19;
      end
      // One quotient bit per cycle
      S_DV: begin
        if (dv_le) begin
          num_r <= dsub[sosc_pkg::NUM_W-1:0];
        end
        dv_r  <= dv_r >> 1;
        q_r   <= {q_r[18:0], dv_le};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          frac_r <= {q_r[18:0], dv_le};
        end
      end
      default: ;
    endcase
  end

  // Output register: load on hand-over, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_status_r <= status_r;
      out_exc_r    <= (total_r > limit_r);
      out_total_r  <= total_r;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = out_status_r;
  assign out_ch.overlap_exceeded = out_exc_r;
  assign out_ch.total_overlap    = out_total_r;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[sosc_pkg::CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r    <= sosc_pkg::WRAP_RST;
      size_r[0] <= sosc_pkg::SIZE_RST;
      size_r[1] <= sosc_pkg::SIZE_RST;
      size_r[2] <= sosc_pkg::SIZE_RST;
      limit_r   <= sosc_pkg::LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        sosc_pkg::REG_WRAP:   wrap_r    <= pwdata[0];
        sosc_pkg::REG_SIZE_X: size_r[0] <= pwdata[sosc_pkg::SIZE_W-1:0];
        sosc_pkg::REG_SIZE_Y: size_r[1] <= pwdata[sosc_pkg::SIZE_W-1:0];
        sosc_pkg::REG_SIZE_Z: size_r[2] <= pwdata[sosc_pkg::SIZE_W-1:0];
        sosc_pkg::REG_LIMIT:  limit_r   <= pwdata[sosc_pkg::FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      sosc_pkg::REG_WRAP:   prdata = 32'(wrap_r);
      sosc_pkg::REG_SIZE_X: prdata = 32'(size_r[0]);
      sosc_pkg::REG_SIZE_Y: prdata = 32'(size_r[1]);
      sosc_pkg::REG_SIZE_Z: prdata = 32'(size_r[2]);
      sosc_pkg::REG_LIMIT:  prdata = 32'(limit_r);
      default:              prdata = '0;
    endcase
  end

  // Checks
  `ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_r <= CNT_W'(MAX_SPHERES))
  `ASSERT_IMP(a_read_in_range, clk, rst_n, state_r == S_LD, idx_r < count_r)
  `ASSERT_IMP(a_lens_root, clk, rst_n, state_r == S_L1, root_r < s_r)
  `ASSERT_NXT(a_total_grows, clk, rst_n, state_r == S_ACC, total_r >= $past(total_r))
  `ASSERT_IMP(a_write_idle, clk, rst_n, ram_we, state_r == S_IDLE)

endmodule
